// File: sv/csrib_pkg.sv
package csrib_pkg;

    localparam int MAX_ROWS    = 256;
    localparam int MAX_ENTRIES = 4096;
    localparam int COLUMN_BITS = 16;
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int RIDX_W      = $clog2(MAX_ROWS + 1);
    localparam int POS_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [2:0] {
        MODE_WRITE_COUNT  = 3'd0,
        MODE_BUILD        = 3'd1,
        MODE_WRITE_COLUMN = 3'd2,
        MODE_SORT         = 3'd3,
        MODE_LOOKUP       = 3'd4
    } mode_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_BUILD_RD,
        ST_BUILD_WAIT,
        ST_BUILD_WR,
        ST_SPAN_RD0,
        ST_SPAN_WAIT0,
        ST_SPAN_RD1,
        ST_SPAN_WAIT1,
        ST_SORT_KEY,
        ST_SORT_KEY_WAIT,
        ST_SORT_CMP,
        ST_SORT_CMP_WAIT,
        ST_SORT_PLACE,
        ST_SEARCH_RD,
        ST_SEARCH_WAIT,
        ST_FINAL_RD,
        ST_FINAL_WAIT,
        ST_DONE
    } state_t;

endpackage

// File: sv/csr_row_index_builder_lookup_top.sv
// CSR index block: holds a row start table (257 entries) and a column store
// (4096 entries), both in single-port memories with registered reads, under
// one sequencer that owns the comparators and adders. An item is taken only
// while the block is idle and gives exactly one result beat. Count and
// column writes, and unused modes, go straight to the result. Lookup reads
// the row span from the start table, then binary-searches the column
// store through its read port. Build walks the rows in use and writes each
// row start as the running sum of counts. Sort is an insertion sort through
// the one store port: each compare reads the store and each shift writes it.
// There is no clearing pass after reset.
module csr_row_index_builder_lookup_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  mode,
    input  logic [7:0]  row,
    input  logic [11:0] position,
    input  logic [15:0] column,
    input  logic [12:0] entry_count,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [11:0] found_position,
    output logic        found,
    output logic [12:0] total_entries,
    output logic        empty_error
);

    localparam int RW = csrib_pkg::RIDX_W;
    localparam int PW = csrib_pkg::POS_W;
    localparam int CW = csrib_pkg::CNT_W;
    localparam int DW = csrib_pkg::COLUMN_BITS;

    csrib_pkg::state_t state_reg, state_next;

    logic [8:0]    row_count_reg;
    logic [RW-1:0] rows;

    // Row start table with valid bits (reset value zero)
    logic [CW-1:0] rs_mem [csrib_pkg::MAX_ROWS+1];
    logic [csrib_pkg::MAX_ROWS:0] rs_valid_reg;
    logic [CW-1:0] rs_rdata_reg;
    logic          rs_rvalid_reg;
    logic [CW-1:0] rs_q;
    logic          rs_we;
    logic [RW-1:0] rs_addr;
    logic [CW-1:0] rs_wdata;

    logic [DW-1:0] cs_mem [csrib_pkg::MAX_ENTRIES];
    logic [DW-1:0] cs_q_reg;
    logic          cs_we;
    logic [PW-1:0] cs_addr;
    logic [DW-1:0] cs_wdata;

    logic [2:0]    mode_reg;
    logic [RW-1:0] row_reg, row_next;
    logic [DW-1:0] col_reg;

    logic [CW:0]   sum_reg, sum_next;
    logic [CW-1:0] s_reg, s_next, e_reg, e_next;
    logic [CW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [CW-1:0] k_reg, k_next, q_reg, q_next;
    logic [DW-1:0] v_reg, v_next;

    logic [CW-1:0] fpos_reg, fpos_next;
    logic          found_reg, found_next;
    logic [CW-1:0] total_reg, total_next;
    logic          empty_reg, empty_next;
    logic [CW-1:0] entry_total_reg, entry_total_next;
    logic          accept;
    logic [CW-1:0] mid;
    logic [CW:0]   sum_add;
    logic [CW-1:0] sat_sum;
    logic [CW-1:0] end_lim;

    assign rows = (row_count_reg > 9'(csrib_pkg::MAX_ROWS))
                ? RW'(csrib_pkg::MAX_ROWS) : RW'(row_count_reg);
    assign cfg_ready = (state_reg == csrib_pkg::ST_IDLE);
    assign in_stall  = (state_reg != csrib_pkg::ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = (state_reg == csrib_pkg::ST_DONE);
    assign found_position = fpos_reg[PW-1:0];
    assign found          = found_reg;
    assign total_entries  = total_reg;
    assign empty_error    = empty_reg;

    assign rs_q    = rs_rvalid_reg ? rs_rdata_reg : '0;
    assign mid     = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign sum_add = sum_reg + {1'b0, rs_q};
    assign sat_sum = (sum_reg > (CW+1)'(csrib_pkg::MAX_ENTRIES))
                   ? CW'(csrib_pkg::MAX_ENTRIES) : sum_reg[CW-1:0];
    assign end_lim = (rs_q > CW'(csrib_pkg::MAX_ENTRIES))
                   ? CW'(csrib_pkg::MAX_ENTRIES) : rs_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= csrib_pkg::ST_IDLE;
            row_count_reg   <= 9'd1;
            rs_valid_reg    <= '0;
            entry_total_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            entry_total_reg <= entry_total_next;
            if (cfg_valid && cfg_ready)
                row_count_reg <= cfg_data;
            if (rs_we)
                rs_valid_reg[rs_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rs_we)
            rs_mem[rs_addr] <= rs_wdata;
        rs_rdata_reg  <= rs_mem[rs_addr];
        rs_rvalid_reg <= rs_valid_reg[rs_addr];
        if (cs_we)
            cs_mem[cs_addr] <= cs_wdata;
        cs_q_reg <= cs_mem[cs_addr];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= mode;
            col_reg  <= column;
        end
        row_reg   <= row_next;
        sum_reg   <= sum_next;
        s_reg     <= s_next;
        e_reg     <= e_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        k_reg     <= k_next;
        q_reg     <= q_next;
        v_reg     <= v_next;
        fpos_reg  <= fpos_next;
        found_reg <= found_next;
        total_reg <= total_next;
        empty_reg <= empty_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            csrib_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (mode)
                        csrib_pkg::MODE_BUILD:
                            state_next = (rows == '0) ? csrib_pkg::ST_DONE
                                                      : csrib_pkg::ST_BUILD_RD;
                        csrib_pkg::MODE_SORT:
                            state_next = (rows == '0) ? csrib_pkg::ST_DONE
                                                      : csrib_pkg::ST_SPAN_RD0;
                        csrib_pkg::MODE_LOOKUP:
                            state_next = ({1'b0, row} < rows) ? csrib_pkg::ST_SPAN_RD0
                                                              : csrib_pkg::ST_DONE;
                        default:
                            state_next = csrib_pkg::ST_DONE;
                    endcase
                end
            end
            csrib_pkg::ST_BUILD_RD:   state_next = csrib_pkg::ST_BUILD_WAIT;
            csrib_pkg::ST_BUILD_WAIT: state_next = csrib_pkg::ST_BUILD_WR;
            csrib_pkg::ST_BUILD_WR:
                state_next = (row_reg == rows) ? csrib_pkg::ST_DONE
                                               : csrib_pkg::ST_BUILD_RD;
            csrib_pkg::ST_SPAN_RD0:   state_next = csrib_pkg::ST_SPAN_WAIT0;
            csrib_pkg::ST_SPAN_WAIT0: state_next = csrib_pkg::ST_SPAN_RD1;
            csrib_pkg::ST_SPAN_RD1:   state_next = csrib_pkg::ST_SPAN_WAIT1;
            csrib_pkg::ST_SPAN_WAIT1:
            begin
                if (mode_reg == csrib_pkg::MODE_LOOKUP)
                    state_next = csrib_pkg::ST_SEARCH_RD;
                else
                    state_next = csrib_pkg::ST_SORT_KEY;
            end
            csrib_pkg::ST_SORT_KEY:
            begin
                if (k_reg >= e_reg)
                    state_next = (row_reg + 1'b1 == rows) ? csrib_pkg::ST_DONE
                                                          : csrib_pkg::ST_SPAN_RD0;
                else
                    state_next = csrib_pkg::ST_SORT_KEY_WAIT;
            end
            csrib_pkg::ST_SORT_KEY_WAIT: state_next = csrib_pkg::ST_SORT_CMP;
            csrib_pkg::ST_SORT_CMP:
                state_next = (q_reg > s_reg) ? csrib_pkg::ST_SORT_CMP_WAIT
                                             : csrib_pkg::ST_SORT_PLACE;
            csrib_pkg::ST_SORT_CMP_WAIT:
                state_next = (cs_q_reg > v_reg) ? csrib_pkg::ST_SORT_CMP
                                                : csrib_pkg::ST_SORT_PLACE;
            csrib_pkg::ST_SORT_PLACE: state_next = csrib_pkg::ST_SORT_KEY;
            csrib_pkg::ST_SEARCH_RD:
                state_next = (lo_reg < hi_reg) ? csrib_pkg::ST_SEARCH_WAIT
                                               : csrib_pkg::ST_FINAL_RD;
            csrib_pkg::ST_SEARCH_WAIT: state_next = csrib_pkg::ST_SEARCH_RD;
            csrib_pkg::ST_FINAL_RD:
                state_next = (lo_reg < e_reg) ? csrib_pkg::ST_FINAL_WAIT
                                              : csrib_pkg::ST_DONE;
            csrib_pkg::ST_FINAL_WAIT: state_next = csrib_pkg::ST_DONE;
            csrib_pkg::ST_DONE:
                if (!out_stall)
                    state_next = csrib_pkg::ST_IDLE;
            default: state_next = csrib_pkg::ST_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        rs_we            = 1'b0;
        rs_addr          = row_reg;
        rs_wdata         = '0;
        cs_we            = 1'b0;
        cs_addr          = lo_reg[PW-1:0];
        cs_wdata         = v_reg;
        row_next         = row_reg;
        sum_next         = sum_reg;
        s_next           = s_reg;
        e_next           = e_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        k_next           = k_reg;
        q_next           = q_reg;
        v_next           = v_reg;
        fpos_next        = fpos_reg;
        found_next       = found_reg;
        total_next       = total_reg;
        empty_next       = empty_reg;
        entry_total_next = entry_total_reg;
        case (state_reg)
            csrib_pkg::ST_IDLE:
            begin
                fpos_next  = '0;
                found_next = 1'b0;
                total_next = '0;
                empty_next = 1'b0;
                sum_next   = '0;
                if (accept)
                begin
                    case (mode)
                        csrib_pkg::MODE_WRITE_COUNT:
                        begin
                            rs_we    = 1'b1;
                            rs_addr  = RW'(row) + 1'b1;
                            rs_wdata = entry_count;
                        end
                        csrib_pkg::MODE_WRITE_COLUMN:
                        begin
                            cs_we    = 1'b1;
                            cs_addr  = position;
                            cs_wdata = column;
                        end
                        csrib_pkg::MODE_BUILD:
                        begin
                            row_next = RW'(1);
                            if (rows == '0)
                            begin
                                // No rows: the total is zero
                                empty_next       = 1'b1;
                                entry_total_next = '0;
                            end
                        end
                        csrib_pkg::MODE_SORT:
                            row_next = '0;
                        default:
                            row_next = RW'(row);
                    endcase
                end
            end
            csrib_pkg::ST_BUILD_RD:
                rs_addr = row_reg;
            csrib_pkg::ST_BUILD_WR:
            begin
                rs_we    = 1'b1;
                rs_addr  = row_reg;
                rs_wdata = sat_sum;
                sum_next = (sum_add > (CW+1)'(csrib_pkg::MAX_ENTRIES + 1))
                         ? (CW+1)'(csrib_pkg::MAX_ENTRIES + 1) : sum_add;
                row_next = row_reg + 1'b1;
                if (row_reg == rows)
                begin
                    empty_next = (sum_add == '0)
                              || (sum_add > (CW+1)'(csrib_pkg::MAX_ENTRIES));
                    entry_total_next = (sum_add > (CW+1)'(csrib_pkg::MAX_ENTRIES))
                                     ? CW'(csrib_pkg::MAX_ENTRIES) : sum_add[CW-1:0];
                    total_next = entry_total_next;
                end
            end
            csrib_pkg::ST_SPAN_RD0:
                rs_addr = row_reg;
            csrib_pkg::ST_SPAN_WAIT0:
                s_next = rs_q;
            csrib_pkg::ST_SPAN_RD1:
                rs_addr = row_reg + 1'b1;
            csrib_pkg::ST_SPAN_WAIT1:
            begin
                e_next  = end_lim;
                s_next  = (s_reg > end_lim) ? end_lim : s_reg;
                lo_next = (s_reg > end_lim) ? end_lim : s_reg;
                hi_next = end_lim;
                k_next  = ((s_reg > end_lim) ? end_lim : s_reg) + 1'b1;
            end
            csrib_pkg::ST_SORT_KEY:
            begin
                cs_addr = k_reg[PW-1:0];
                q_next  = k_reg;
                if (k_reg >= e_reg)
                    row_next = row_reg + 1'b1;
            end
            csrib_pkg::ST_SORT_KEY_WAIT:
                v_next = cs_q_reg;
            csrib_pkg::ST_SORT_CMP:
                cs_addr = PW'(q_reg - 1'b1);
            csrib_pkg::ST_SORT_CMP_WAIT:
            begin
                if (cs_q_reg > v_reg)
                begin
                    // Shift the larger entry up one place
                    cs_we    = 1'b1;
                    cs_addr  = q_reg[PW-1:0];
                    cs_wdata = cs_q_reg;
                    q_next   = q_reg - 1'b1;
                end
            end
            csrib_pkg::ST_SORT_PLACE:
            begin
                cs_we    = 1'b1;
                cs_addr  = q_reg[PW-1:0];
                cs_wdata = v_reg;
                k_next   = k_reg + 1'b1;
            end
            csrib_pkg::ST_SEARCH_RD:
                cs_addr = mid[PW-1:0];
            csrib_pkg::ST_SEARCH_WAIT:
            begin
                if (cs_q_reg < col_reg)
                    lo_next = mid + 1'b1;
                else
                    hi_next = mid;
            end
            csrib_pkg::ST_FINAL_RD:
                cs_addr = lo_reg[PW-1:0];
            csrib_pkg::ST_FINAL_WAIT:
            begin
                if (cs_q_reg == col_reg)
                begin
                    found_next = 1'b1;
                    fpos_next  = lo_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// File: tb/csr_row_index_builder_lookup_top_tb.sv
`timescale 1ns / 100ps

module csr_row_index_builder_lookup_top_tb;

    localparam int LIMIT_CYCLES = 4000000;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  r;
        logic [11:0] p;
        logic [15:0] c;
        logic [12:0] n;
    } beat_in_t;

    typedef struct packed {
        logic [11:0] fpos;
        logic        hit;
        logic [12:0] total;
        logic        empty;
    } beat_out_t;

    typedef struct {
        beat_in_t  stim;
        bit        typed;
        beat_out_t res;
    } table_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [8:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  mode;
    logic [7:0]  row;
    logic [11:0] position;
    logic [15:0] column;
    logic [12:0] entry_count;
    logic        out_valid;
    logic        out_stall;
    logic [11:0] found_position;
    logic        found;
    logic [12:0] total_entries;
    logic        empty_error;

    // predictor state
    logic [8:0]  rows_reg;
    logic [12:0] start_tab [0:csrib_pkg::MAX_ROWS];
    logic [15:0] col_mem [0:csrib_pkg::MAX_ENTRIES-1];
    bit          col_written [0:csrib_pkg::MAX_ENTRIES-1];
    logic [12:0] total_reg;

    beat_out_t   pending_results [$];
    int          errors;
    int          cycles = 0;
    int          n_items;
    int          n_results;
    int          n_hits;
    int          n_builds;

    csr_row_index_builder_lookup_top DUT
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .row            (row),
        .position       (position),
        .column         (column),
        .entry_count    (entry_count),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .found_position (found_position),
        .found          (found),
        .total_entries  (total_entries),
        .empty_error    (empty_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Timed out after %0d cycles", cycles);
            $display("csr_row_index_builder_lookup_top_tb failed");
            $finish;
        end
    end

    function automatic int rows_active();
        return (rows_reg > csrib_pkg::MAX_ROWS) ? csrib_pkg::MAX_ROWS : int'(rows_reg);
    endfunction

    function automatic void span_of(input int r, output int s, output int e);
        int a;
        int b;
        a = int'(start_tab[r]);
        b = int'(start_tab[r + 1]);
        if (b > csrib_pkg::MAX_ENTRIES) b = csrib_pkg::MAX_ENTRIES;
        if (a > b) a = b;
        s = a;
        e = b;
    endfunction

    function automatic beat_out_t csr_predict(input beat_in_t it);
        beat_out_t o;
        int        nrows;
        int        sum;
        int        cnt;
        int        s;
        int        e;
        int        lo;
        int        hi;
        int        mid;
        int        q;
        logic [15:0] v;
        o = '0;
        nrows = rows_active();
        case (it.op)
            csrib_pkg::MODE_WRITE_COUNT:
                start_tab[int'(it.r) + 1] = it.n;
            csrib_pkg::MODE_BUILD:
            begin
                sum = 0;
                for (int r = 1; r <= nrows; r++)
                begin
                    cnt = int'(start_tab[r]);
                    start_tab[r] = 13'((sum > csrib_pkg::MAX_ENTRIES)
                                       ? csrib_pkg::MAX_ENTRIES : sum);
                    sum += cnt;
                end
                start_tab[0] = '0;
                o.empty = (sum == 0 || sum > csrib_pkg::MAX_ENTRIES);
                total_reg = 13'((sum > csrib_pkg::MAX_ENTRIES)
                                ? csrib_pkg::MAX_ENTRIES : sum);
                o.total = total_reg;
            end
            csrib_pkg::MODE_WRITE_COLUMN:
            begin
                col_mem[it.p] = it.c;
                col_written[it.p] = 1'b1;
            end
            csrib_pkg::MODE_SORT:
                for (int r = 0; r < nrows; r++)
                begin
                    span_of(r, s, e);
                    for (int k = s + 1; k < e; k++)
                    begin
                        v = col_mem[k];
                        q = k;
                        while (q > s && col_mem[q - 1] > v)
                        begin
                            col_mem[q] = col_mem[q - 1];
                            q--;
                        end
                        col_mem[q] = v;
                    end
                end
            csrib_pkg::MODE_LOOKUP:
                if (it.r < nrows)
                begin
                    span_of(int'(it.r), s, e);
                    lo = s;
                    hi = e;
                    while (lo < hi)
                    begin
                        mid = lo + (hi - lo) / 2;
                        if (col_mem[mid] < it.c) lo = mid + 1;
                        else hi = mid;
                    end
                    if (lo < e && col_mem[lo] == it.c)
                    begin
                        o.hit = 1'b1;
                        o.fpos = 12'(lo);
                    end
                end
            default:
                o = '0;
        endcase
        return o;
    endfunction

    // every store entry that a sort or lookup can touch must have been written
    function automatic bit spans_written();
        int s;
        int e;
        for (int r = 0; r < rows_active(); r++)
        begin
            span_of(r, s, e);
            for (int k = s; k < e; k++)
                if (!col_written[k]) return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge clk)
    begin
        beat_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing expected");
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (want.hit) n_hits++;
                if (found_position !== want.fpos)
                begin
                    $error("found_position expected %0d got %0d", want.fpos, found_position);
                    errors++;
                end
                if (found !== want.hit)
                begin
                    $error("found expected %0d got %0d", want.hit, found);
                    errors++;
                end
                if (total_entries !== want.total)
                begin
                    $error("total_entries expected %0d got %0d", want.total, total_entries);
                    errors++;
                end
                if (empty_error !== want.empty)
                begin
                    $error("empty_error expected %0d got %0d", want.empty, empty_error);
                    errors++;
                end
            end
        end
    end

    // result side: random stall per beat
    initial
    begin
        int gap;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
            repeat (gap) @(posedge clk);
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            out_stall <= 1'b1;
        end
    end

    // hold valid across back-to-back beats, drop it only for an idle gap
    task automatic drive_beat(input beat_in_t it, input bit typed, input beat_out_t res);
        beat_out_t want;
        int        gap;
        gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        want = csr_predict(it);
        if (typed && want !== res)
        begin
            $error("table row disagrees: expected %h predicted %h", res, want);
            errors++;
        end
        pending_results.push_back(want);
        mode        <= it.op;
        row         <= it.r;
        position    <= it.p;
        column      <= it.c;
        entry_count <= it.n;
        in_valid    <= 1'b1;
        do @(posedge clk); while (in_stall);
        n_items++;
        if (it.op == csrib_pkg::MODE_BUILD) n_builds++;
    endtask

    task automatic quiesce();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_rows(input logic [8:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        rows_reg = value;
    endtask

    function automatic beat_in_t mk(input logic [2:0] op, input int r, input int p,
                                    input int c, input int n);
        beat_in_t it;
        it.op = op;
        it.r  = 8'(r);
        it.p  = 12'(p);
        it.c  = 16'(c);
        it.n  = 13'(n);
        return it;
    endfunction

    // random well-formed phase: counts, build, fill, sort, then lookups
    task automatic matrix_phase(input int nrows, input int max_cnt, input int lookups);
        int        nnz;
        int        mx;
        beat_in_t  it;
        beat_out_t none;
        logic [15:0] cols [$];
        none = '0;
        quiesce();
        write_rows(9'(nrows));
        for (int r = 0; r < nrows; r++)
            drive_beat(mk(csrib_pkg::MODE_WRITE_COUNT, r, $urandom, $urandom,
                          $urandom_range(0, max_cnt)), 0, none);
        drive_beat(mk(csrib_pkg::MODE_BUILD, 0, 0, 0, 0), 0, none);
        nnz = int'(total_reg);
        mx = ($urandom_range(0, 1) == 0) ? 16 : 65535;
        cols.delete();
        for (int k = 0; k < nnz; k++)
        begin
            cols.push_back(16'($urandom_range(0, mx)));
            drive_beat(mk(csrib_pkg::MODE_WRITE_COLUMN, $urandom, k, int'(cols[k]),
                          $urandom), 0, none);
        end
        if (spans_written())
            drive_beat(mk(csrib_pkg::MODE_SORT, 0, 0, 0, 0), 0, none);
        for (int i = 0; i < lookups; i++)
        begin
            it = mk(csrib_pkg::MODE_LOOKUP, $urandom_range(0, nrows), $urandom,
                    $urandom_range(0, mx), $urandom);
            if (nnz > 0 && $urandom_range(0, 2) != 0)
                it.c = cols[$urandom_range(0, nnz - 1)];
            if ($urandom_range(0, 15) == 0)
                it.op = 3'($urandom_range(5, 7));
            if (spans_written())
                drive_beat(it, 0, none);
        end
    endtask

    initial
    begin
        table_row_t dir [$];
        beat_out_t  z;
        beat_out_t  t;
        z = '0;
        errors = 0;
        n_items = 0;
        n_results = 0;
        n_hits = 0;
        n_builds = 0;
        rows_reg = 9'd1;
        total_reg = '0;
        for (int i = 0; i <= csrib_pkg::MAX_ROWS; i++) start_tab[i] = '0;
        for (int i = 0; i < csrib_pkg::MAX_ENTRIES; i++)
        begin
            col_mem[i] = '0;
            col_written[i] = 1'b0;
        end
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        mode = '0;
        row = '0;
        position = '0;
        column = '0;
        entry_count = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset state, extremes, error flags, unused modes
        t = z; t.empty = 1'b1;
        dir.push_back('{mk(csrib_pkg::MODE_BUILD, 0, 0, 0, 0), 1, t});
        dir.push_back('{mk(csrib_pkg::MODE_LOOKUP, 0, 0, 0, 0), 1, z});
        dir.push_back('{mk(csrib_pkg::MODE_LOOKUP, 255, 4095, 65535, 8191), 1, z});
        dir.push_back('{mk(3'd5, 255, 4095, 65535, 8191), 1, z});
        dir.push_back('{mk(3'd6, 0, 0, 0, 0), 1, z});
        dir.push_back('{mk(3'd7, 85, 2730, 43690, 5461), 1, z});
        dir.push_back('{mk(csrib_pkg::MODE_WRITE_COUNT, 255, 4095, 65535, 8191), 1, z});
        dir.push_back('{mk(csrib_pkg::MODE_WRITE_COUNT, 0, 0, 0, 4096), 1, z});
        t = z; t.total = 13'd4096;
        dir.push_back('{mk(csrib_pkg::MODE_BUILD, 0, 0, 0, 0), 1, t});
        dir.push_back('{mk(csrib_pkg::MODE_WRITE_COUNT, 0, 0, 0, 8191), 1, z});
        t = z; t.total = 13'd4096; t.empty = 1'b1;
        dir.push_back('{mk(csrib_pkg::MODE_BUILD, 0, 0, 0, 0), 1, t});
        dir.push_back('{mk(csrib_pkg::MODE_WRITE_COUNT, 0, 0, 0, 3), 1, z});
        t = z; t.total = 13'd3;
        dir.push_back('{mk(csrib_pkg::MODE_BUILD, 0, 0, 0, 0), 1, t});
        dir.push_back('{mk(csrib_pkg::MODE_WRITE_COLUMN, 0, 0, 65535, 0), 1, z});
        dir.push_back('{mk(csrib_pkg::MODE_WRITE_COLUMN, 0, 1, 7, 0), 1, z});
        dir.push_back('{mk(csrib_pkg::MODE_WRITE_COLUMN, 0, 2, 7, 0), 1, z});
        dir.push_back('{mk(csrib_pkg::MODE_WRITE_COLUMN, 255, 4095, 0, 8191), 1, z});
        // row 0 ends at entry 0, so give it three entries again for the sort
        dir.push_back('{mk(csrib_pkg::MODE_WRITE_COUNT, 0, 0, 0, 3), 1, z});
        dir.push_back('{mk(csrib_pkg::MODE_SORT, 0, 0, 0, 0), 1, z});
        t = z; t.hit = 1'b1;
        dir.push_back('{mk(csrib_pkg::MODE_LOOKUP, 0, 0, 7, 0), 1, t});
        t.fpos = 12'd2;
        dir.push_back('{mk(csrib_pkg::MODE_LOOKUP, 0, 0, 65535, 0), 1, t});
        dir.push_back('{mk(csrib_pkg::MODE_LOOKUP, 0, 0, 8, 0), 1, z});
        dir.push_back('{mk(csrib_pkg::MODE_LOOKUP, 1, 0, 7, 0), 1, z});
        foreach (dir[i])
            drive_beat(dir[i].stim, dir[i].typed, dir[i].res);

        // register extremes: zero rows, then the largest value
        quiesce();
        write_rows(9'd0);
        drive_beat(mk(csrib_pkg::MODE_LOOKUP, 0, 0, 7, 0), 0, z);
        drive_beat(mk(csrib_pkg::MODE_BUILD, 0, 0, 0, 0), 0, z);
        quiesce();
        write_rows(9'd511);
        for (int r = 0; r < 256; r++)
            drive_beat(mk(csrib_pkg::MODE_WRITE_COUNT, r, 0, 0, r[0] ? 1 : 0), 0, z);
        drive_beat(mk(csrib_pkg::MODE_LOOKUP, 255, 0, 0, 0), 0, z);
        drive_beat(mk(csrib_pkg::MODE_BUILD, 0, 0, 0, 0), 0, z);

        matrix_phase(256, 3, 40);
        while (n_items < 1450)
            matrix_phase($urandom_range(0, 7) == 0 ? $urandom_range(20, 64)
                                                  : $urandom_range(1, 8),
                         $urandom_range(0, 3) == 0 ? 12 : 5, 40);
        quiesce();

        $display("Drove %0d items (%0d offset builds), checked %0d result beats",
                 n_items, n_builds, n_results);
        $display("Lookups that hit: %0d, over row counts from none to the register maximum",
                 n_hits);
        if (errors == 0)
            $display("csr_row_index_builder_lookup_top_tb passed");
        else
            $display("csr_row_index_builder_lookup_top_tb failed");
        $finish;
    end

endmodule
